// ===== hw/rtl/bf2x2_pkg.sv =====
// Shared types and constants for the 2x2 rounded box filter.
// No dependencies; imported by the line memory and the top level.
`default_nettype none

package bf2x2_pkg;

   localparam int unsigned MAX_LINE_DEFAULT = 1024;
   localparam int unsigned PIX_W            = 8;
   localparam int unsigned DIM_W            = 11;
   localparam int unsigned ROW_W            = 10;
   localparam int unsigned MAX_ROWS         = 1024;
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam int unsigned CSR_DATA_W       = 32;
   localparam int unsigned SUM_W            = PIX_W + 2;

   typedef logic [PIX_W-1:0]      pixel_type;
   typedef logic [DIM_W-1:0]      dim_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam dim_type LINE_WIDTH_RESET   = dim_type'(640);
   localparam dim_type FRAME_HEIGHT_RESET = dim_type'(480);
   localparam dim_type DIM_MIN            = dim_type'(2);
   localparam dim_type ROWS_MAX           = dim_type'(MAX_ROWS);

   // rounding bias for the divide-by-four
   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(2);

   // register select, taken from address bit 2 (word index)
   typedef enum logic {
      REG_LINE_WIDTH   = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bf2x2_line_mem.sv =====
// One-line pixel store: synchronous memory, one access per cycle.
// Read returns the old entry when read and write hit the same address.
// Depends on bf2x2_pkg.
`default_nettype none

module bf2x2_line_mem #(
   parameter int unsigned DEPTH = bf2x2_pkg::MAX_LINE_DEFAULT,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [AW-1:0]         addr,
   input  wire bf2x2_pkg::pixel_type  wr_data,
   output      bf2x2_pkg::pixel_type  rd_data
);
   import bf2x2_pkg::*;

   pixel_type mem [DEPTH];
   pixel_type rd_data_ff;

   // read-modify-write of one entry: old value out, new value in
   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/box_filter_2x2_rounded_top.sv =====
// 2x2 rounded box filter, top level.
// Input stream (req_*): one 8-bit pixel per beat, raster order. Output stream
// (rsp_*): one beat per 2x2 window, value (a+b+c+d+2)/4; rsp_tlast marks the
// last beat of an output row, rsp_tuser the last beat of the frame.
// A W x H frame gives (W-1) x (H-1) beats; row 0 and column 0 give none.
// Frame size comes from two APB registers (line_width at 0x0, frame_height
// at 0x4, values clamped to 2..MAX_LINE and 2..1024). Write them while idle.
// A pixel's result passes through the stage-1 register and then the output
// register, which drives rsp_tvalid.
// Throughput: one pixel per cycle while the rsp side does not stall, set by
// the line memory doing one read-modify-write per pixel.
// Reset clears the counters, neighbour registers and both pipeline valids;
// the line memory is not cleared (every entry is written before it is read).
// A stalled rsp side holds the output register; the pipeline stage behind it
// keeps moving while it carries pixels with no result, then backs up and
// drops req_tready.
// Depends on bf2x2_pkg and bf2x2_line_mem.
`default_nettype none

module box_filter_2x2_rounded_top #(
   parameter int unsigned MAX_LINE = bf2x2_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input stream
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire bf2x2_pkg::pixel_type     req_tdata,   // [7:0] pixel
   // result stream
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      bf2x2_pkg::pixel_type     rsp_tdata,   // [7:0] filtered
   output      logic                     rsp_tlast,   // row_end
   output      logic [0:0]               rsp_tuser,   // [0] frame_end
   // configuration
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire bf2x2_pkg::csr_addr_type  csr_paddr,
   input  wire bf2x2_pkg::csr_data_type  csr_pwdata,
   output      bf2x2_pkg::csr_data_type  csr_prdata,
   output      logic                     csr_pready
);
   import bf2x2_pkg::*;

   // column counter holds 0..MAX_LINE-1; compare width also covers the register
   localparam int unsigned CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
   localparam int unsigned EW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
   localparam logic [EW-1:0] WIDTH_MAX = EW'(MAX_LINE);
   localparam logic [EW-1:0] WIDTH_MIN = EW'(DIM_MIN);

   // ---------------- configuration registers ----------------
   dim_type     line_width_ff, line_width_in;
   dim_type     frame_height_ff, frame_height_in;
   logic        csr_wr;
   csr_reg_type csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      csr_prdata      = '0;
      unique case (csr_sel)
         REG_LINE_WIDTH: begin
            csr_prdata = CSR_DATA_W'(line_width_ff);
            if (csr_wr) line_width_in = csr_pwdata[DIM_W-1:0];
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_W'(frame_height_ff);
            if (csr_wr) frame_height_in = csr_pwdata[DIM_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // effective (clamped) frame size
   logic [EW-1:0] w_eff;
   dim_type       h_eff;
   logic [EW-1:0] lw_ext;

   assign lw_ext = EW'(line_width_ff);

   always_comb begin
      if (lw_ext < WIDTH_MIN)      w_eff = WIDTH_MIN;
      else if (lw_ext > WIDTH_MAX) w_eff = WIDTH_MAX;
      else                         w_eff = lw_ext;
      if (frame_height_ff < DIM_MIN)       h_eff = DIM_MIN;
      else if (frame_height_ff > ROWS_MAX) h_eff = ROWS_MAX;
      else                                 h_eff = frame_height_ff;
   end

   // ---------------- stage 0: position, memory access ----------------
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;
   logic             col_wrap;
   logic [CW-1:0]    col_cur;
   dim_type          row_inc;
   logic [ROW_W-1:0] row_cur;
   logic [EW-1:0]    col_nxt;
   dim_type          row_nxt;
   logic             col_last, row_last;
   logic             emit0;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      // a counter left beyond a shrunk size wraps before use
      col_wrap = EW'(col_ff) >= w_eff;
      col_cur  = col_wrap ? '0 : col_ff;
      row_inc  = DIM_W'(row_ff) + DIM_W'(col_wrap);
      row_cur  = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];

      col_nxt  = EW'(col_cur) + EW'(1);
      row_nxt  = DIM_W'(row_cur) + DIM_W'(1);
      col_last = col_nxt >= w_eff;
      row_last = row_nxt >= h_eff;
      emit0    = (row_cur != '0) && (col_cur != '0);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_nxt[ROW_W-1:0];
         end else begin
            col_in = col_nxt[CW-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   pixel_type upper;

   bf2x2_line_mem #(.DEPTH(MAX_LINE)) u_line_mem (
      .clock   (clock),
      .enable  (accept),
      .addr    (col_cur),
      .wr_data (req_tdata),
      .rd_data (upper)
   );

   // ---------------- stage 1: window sum ----------------
   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pix_ff;
   logic      s1_emit_ff, s1_re_ff, s1_fe_ff;
   logic      s1_adv;
   pixel_type left_ff, upper_left_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_data_ff;
   logic      rsp_last_ff, rsp_frame_ff;
   logic [SUM_W-1:0] sum;

   // a pixel with no result never waits on the output register
   assign s1_adv     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   assign sum = SUM_W'(upper_left_ff) + SUM_W'(upper) + SUM_W'(left_ff)
              + SUM_W'(s1_pix_ff) + ROUND_BIAS;

   always_comb begin
      if (accept)      s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
      else             s1_valid_in = s1_valid_ff;

      if (s1_adv && s1_emit_ff) rsp_valid_in = 1'b1;
      else if (rsp_tready)      rsp_valid_in = 1'b0;
      else                      rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            left_ff       <= s1_pix_ff;
            upper_left_ff <= upper;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_emit_ff <= emit0;
         s1_re_ff   <= col_last;
         s1_fe_ff   <= col_last && row_last;
      end
      if (s1_adv && s1_emit_ff) begin
         rsp_data_ff  <= sum[SUM_W-1:2];
         rsp_last_ff  <= s1_re_ff;
         rsp_frame_ff <= s1_fe_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_frame_ff;

endmodule

`default_nettype wire
